// ----- rtl/core/wsfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfd_pkg: shared types and constants of the WebSocket frame decoder
// Result codes, header field constants and the result record that passes
// from the frame parser to the result register.
// ----------------------------------------------------------------------------
package wsfd_pkg;

   localparam int unsigned LEN_WIDTH = 21;

   // Result kinds.
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_EMPTY = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Second header byte: seven-bit length codes that call for extended lengths.
   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   // Number of extension length bytes and of mask key bytes.
   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   // Reset value of the payload length limit: one mebibyte.
   localparam logic [LEN_WIDTH-1:0] MAX_PAYLOAD_RESET = LEN_WIDTH'(1 * 1024 * 1024);

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic [3:0] frame_opcode;
      logic [7:0] payload_byte;
      logic       frame_end;
   } result_type;

endpackage

// ----- rtl/core/wsfd_channels.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfd_channels: valid/ready channels of the WebSocket frame decoder
// Stream byte input, decoded result output and the limit register write port.
// ----------------------------------------------------------------------------
interface wsfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink (input valid, input stream_byte, output ready);
endinterface

interface wsfd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [3:0] frame_opcode;
   logic [7:0] payload_byte;
   logic       frame_end;

   modport source (output valid, output kind, output frame_opcode,
                   output payload_byte, output frame_end, input ready);
   modport sink (input valid, input kind, input frame_opcode,
                 input payload_byte, input frame_end, output ready);
endinterface

interface wsfd_csr_if;
   logic        valid;
   logic        ready;
   logic [20:0] max_payload_len;

   modport source (output valid, output max_payload_len, input ready);
   modport sink (input valid, input max_payload_len, output ready);
endinterface

// ----- rtl/core/websocket_frame_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_decoder: byte-serial WebSocket frame receiver
// Parses frame headers from a byte stream and delivers unmasked payload bytes.
// ----------------------------------------------------------------------------
// Usage.
// The req channel carries one raw stream byte per transfer. Each byte moves
// the frame parser on by one step: header bytes, extended length bytes and
// mask key bytes give no result, every payload byte gives one result on the
// rsp channel, a frame with zero length gives one empty-frame result, and a
// length above the limit gives one error result.
// The csr channel writes the payload length limit (reset value 1048576). It
// must be written by the user only while the block is idle; the block does
// not enforce this. A write is always taken at once. The result of a byte is
// shown on rsp in the cycle after its transfer. Throughput is one byte per
// cycle, set by the single result register, which may be reloaded in the same
// cycle that it empties. When the receiver stalls, the result stays in the
// register and req is held off only if the register is full and not being
// emptied. After an error result the parser is halted: further bytes are still
// taken but give no result until reset. Reset is synchronous and active high; it
// returns the parser to the first header byte and empties the result register.
// ----------------------------------------------------------------------------
module websocket_frame_decoder (
   input  logic              clock,
   input  logic              reset,
   wsfd_req_if.sink          req_chan,
   wsfd_rsp_if.source        rsp_chan,
   wsfd_csr_if.sink          csr_chan
);

   localparam int unsigned LW = wsfd_pkg::LEN_WIDTH;

   logic [LW-1:0]        max_len_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   wsfd_pkg::result_type rsp_data_ff;
   wsfd_pkg::result_type step_result;
   logic                 accept;

   // The limit register takes every write in the cycle it is offered.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= wsfd_pkg::MAX_PAYLOAD_RESET;
      end else if (csr_chan.valid) begin
         max_len_ff <= csr_chan.max_payload_len;
      end
   end

   // A byte is taken whenever the result register is empty or being emptied.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   wsfd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .stream_byte (req_chan.stream_byte),
      .max_len     (max_len_ff),
      .result      (step_result)
   );

   // The result register fills on a byte that causes a result and empties
   // when its transfer completes with no new result behind it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = step_result.valid;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && step_result.valid) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = rsp_data_ff.kind;
   assign rsp_chan.frame_opcode = rsp_data_ff.frame_opcode;
   assign rsp_chan.payload_byte = rsp_data_ff.payload_byte;
   assign rsp_chan.frame_end    = rsp_data_ff.frame_end;

endmodule

// ----- rtl/core/wsfd_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsfd_parser: frame header and payload state machine
// Advances the frame state by one accepted byte and gives the result, if any,
// that the byte causes.
// ----------------------------------------------------------------------------
module wsfd_parser (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [7:0]                     stream_byte,
   input  logic [wsfd_pkg::LEN_WIDTH-1:0] max_len,
   output wsfd_pkg::result_type           result
);

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXTLEN,
      PH_MASK,
      PH_PAYLOAD,
      PH_HALT
   } phase_type;

   localparam int unsigned LW = wsfd_pkg::LEN_WIDTH;

   phase_type       phase_ff, phase_in;
   logic [3:0]      opcode_ff, opcode_in;
   logic            masked_ff, masked_in;
   logic [LW-1:0]   accum_ff, accum_in;
   logic            big_ff, big_in;
   logic [3:0]      count_ff, count_in;
   logic [31:0]     key_ff, key_in;
   logic [LW-1:0]   remain_ff, remain_in;
   logic [1:0]      pos_ff, pos_in;

   logic [7:0]      key_byte;
   logic [LW-1:0]   remain_dec;

   always_comb begin
      case (pos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   assign remain_dec = remain_ff - LW'(1);

   always_comb begin
      logic len_done;
      logic hdr_done;

      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      masked_in = masked_ff;
      accum_in  = accum_ff;
      big_in    = big_ff;
      count_in  = count_ff;
      key_in    = key_ff;
      remain_in = remain_ff;
      pos_in    = pos_ff;
      len_done  = 1'b0;
      hdr_done  = 1'b0;

      result              = '0;
      result.frame_opcode = opcode_ff;

      case (phase_ff)
         PH_HDR0: begin
            opcode_in = stream_byte[3:0];
            key_in    = '0;
            phase_in  = PH_HDR1;
         end
         PH_HDR1: begin
            masked_in = stream_byte[7];
            accum_in  = LW'(stream_byte[6:0]);
            big_in    = 1'b0;
            if (stream_byte[6:0] == wsfd_pkg::LEN7_EXT16) begin
               accum_in = '0;
               count_in = wsfd_pkg::EXT16_BYTES;
               phase_in = PH_EXTLEN;
            end else if (stream_byte[6:0] == wsfd_pkg::LEN7_EXT64) begin
               accum_in = '0;
               count_in = wsfd_pkg::EXT64_BYTES;
               phase_in = PH_EXTLEN;
            end else begin
               len_done = 1'b1;
            end
         end
         PH_EXTLEN: begin
            // Bits that leave the 21-bit window mark the length as too large.
            big_in   = big_ff | (accum_ff[LW-1:LW-8] != 8'd0);
            accum_in = {accum_ff[LW-9:0], stream_byte};
            count_in = count_ff - 4'd1;
            len_done = (count_ff == 4'd1);
         end
         PH_MASK: begin
            key_in   = {key_ff[23:0], stream_byte};
            count_in = count_ff - 4'd1;
            hdr_done = (count_ff == 4'd1);
         end
         PH_PAYLOAD: begin
            pos_in              = pos_ff + 2'd1;
            remain_in           = remain_dec;
            result.valid        = 1'b1;
            result.kind         = wsfd_pkg::KIND_DATA;
            result.payload_byte = masked_ff ? (stream_byte ^ key_byte) : stream_byte;
            result.frame_end    = (remain_dec == '0);
            if (remain_dec == '0) begin
               phase_in = PH_HDR0;
            end
         end
         default: begin
            phase_in = PH_HALT;
         end
      endcase

      if (len_done) begin
         if (big_in || (accum_in > max_len)) begin
            phase_in         = PH_HALT;
            result.valid     = 1'b1;
            result.kind      = wsfd_pkg::KIND_ERROR;
            result.frame_end = 1'b1;
         end else begin
            remain_in = accum_in;
            if (masked_in) begin
               count_in = wsfd_pkg::KEY_BYTES;
               phase_in = PH_MASK;
            end else begin
               hdr_done = 1'b1;
            end
         end
      end

      if (hdr_done) begin
         if (remain_in == '0) begin
            phase_in         = PH_HDR0;
            result.valid     = 1'b1;
            result.kind      = wsfd_pkg::KIND_EMPTY;
            result.frame_end = 1'b1;
         end else begin
            pos_in   = 2'd0;
            phase_in = PH_PAYLOAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         opcode_ff <= '0;
         masked_ff <= 1'b0;
         accum_ff  <= '0;
         big_ff    <= 1'b0;
         count_ff  <= '0;
         key_ff    <= '0;
         remain_ff <= '0;
         pos_ff    <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         masked_ff <= masked_in;
         accum_ff  <= accum_in;
         big_ff    <= big_in;
         count_ff  <= count_in;
         key_ff    <= key_in;
         remain_ff <= remain_in;
         pos_ff    <= pos_in;
      end
   end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the WebSocket frame decoder
// Streams well-formed frames with random content, every length encoding and
// a range of payload limits into the decoder, predicts each result in a
// behavioural copy of the frame parser, and checks every result transfer in
// order. It ends with an over-limit frame, after which the parser must stay
// silent.
// ----------------------------------------------------------------------------
module testbench;

   localparam int LW                = wsfd_pkg::LEN_WIDTH;
   localparam int CLOCK_PERIOD      = 10;
   localparam int RESET_CYCLES      = 12;
   // The settle time, in cycles, before a limit write.
   localparam int SETTLE_CYCLES     = 4;
   // Cycles with no transfer on any channel before the run is abandoned.
   localparam int STALL_LIMIT       = 5000;
   // Length of the deliberate receiver hold-off in the back-pressure test.
   localparam int LONG_STALL_CYCLES = 200;
   localparam int TRAFFIC_BYTES     = 440;

   // How the length of a frame is encoded in its header.
   typedef enum logic [1:0] {SHORT_LEN, EXT16_LEN, EXT64_LEN} length_form_type;

   // Where the parser stands in the byte stream.
   typedef enum logic [2:0] {
      AWAIT_OPCODE, AWAIT_LENGTH, AWAIT_EXT_LEN, AWAIT_KEY, AWAIT_PAYLOAD, HALTED
   } parse_phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] opcode;
      logic [7:0] data;
      logic       last;
   } decoded_type;

   logic clock = 1'b0;
   logic reset;

   wsfd_req_if req_chan ();
   wsfd_rsp_if rsp_chan ();
   wsfd_csr_if csr_chan ();

   websocket_frame_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Idling of each side, in percent of cycles, changed from phase to phase.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   // Run bookkeeping.
   int unsigned failures           = 0;
   int unsigned bytes_accepted     = 0;
   int unsigned data_results       = 0;
   int unsigned empty_results      = 0;
   int unsigned error_results      = 0;
   int unsigned input_stall_cycles = 0;
   int unsigned stall_requested    = 0;
   int unsigned stall_served       = 0;
   int unsigned idle_cycles        = 0;

   // Results predicted but not yet seen on the result channel, oldest first.
   decoded_type expected_results[$];

   // Behavioural copy of the frame parser, starting from its reset state.
   parse_phase_type        parse_phase  = AWAIT_OPCODE;
   logic [3:0]             cur_opcode   = '0;
   logic                   cur_masked   = 1'b0;
   logic [63:0]            cur_length   = '0;
   logic [3:0]             bytes_left   = '0;
   logic [31:0]            cur_key      = '0;
   logic [LW-1:0]          payload_left = '0;
   logic [1:0]             key_index    = '0;
   logic [LW-1:0]          length_limit = wsfd_pkg::MAX_PAYLOAD_RESET;

   function automatic void expect_result(input logic [1:0] kind, input logic [7:0] data,
                                         input logic last);
      expected_results.push_back('{kind: kind, opcode: cur_opcode, data: data, last: last});
   endfunction

   // The header is complete: either the frame is empty or its payload begins.
   function automatic void finish_header();
      if (payload_left == '0) begin
         parse_phase = AWAIT_OPCODE;
         expect_result(wsfd_pkg::KIND_EMPTY, 8'h00, 1'b1);
      end else begin
         key_index   = '0;
         parse_phase = AWAIT_PAYLOAD;
      end
   endfunction

   // The length is complete. All 64 bits count in the comparison with the
   // limit, and an over-limit length halts the parser before any mask key.
   function automatic void finish_length();
      if (cur_length > 64'(length_limit)) begin
         parse_phase = HALTED;
         expect_result(wsfd_pkg::KIND_ERROR, 8'h00, 1'b1);
      end else begin
         payload_left = cur_length[LW-1:0];
         if (cur_masked) begin
            bytes_left  = wsfd_pkg::KEY_BYTES;
            parse_phase = AWAIT_KEY;
         end else begin
            finish_header();
         end
      end
   endfunction

   // Moves the parser copy on by one accepted stream byte.
   function automatic void decode_stream_byte(input logic [7:0] b);
      logic [7:0] key_byte;
      logic       last;
      case (parse_phase)
         AWAIT_OPCODE: begin
            // FIN and RSV bits play no part.
            cur_opcode  = b[3:0];
            cur_key     = '0;
            parse_phase = AWAIT_LENGTH;
         end
         AWAIT_LENGTH: begin
            cur_masked = b[7];
            cur_length = '0;
            if (b[6:0] == wsfd_pkg::LEN7_EXT16) begin
               bytes_left  = wsfd_pkg::EXT16_BYTES;
               parse_phase = AWAIT_EXT_LEN;
            end else if (b[6:0] == wsfd_pkg::LEN7_EXT64) begin
               bytes_left  = wsfd_pkg::EXT64_BYTES;
               parse_phase = AWAIT_EXT_LEN;
            end else begin
               cur_length = 64'(b[6:0]);
               finish_length();
            end
         end
         AWAIT_EXT_LEN: begin
            cur_length = {cur_length[55:0], b};
            bytes_left = bytes_left - 4'd1;
            if (bytes_left == '0) finish_length();
         end
         AWAIT_KEY: begin
            cur_key    = {cur_key[23:0], b};
            bytes_left = bytes_left - 4'd1;
            if (bytes_left == '0) finish_header();
         end
         AWAIT_PAYLOAD: begin
            key_byte     = cur_masked ? cur_key[8 * (3 - int'(key_index)) +: 8] : 8'h00;
            key_index    = key_index + 2'd1;
            payload_left = payload_left - 1'b1;
            last         = (payload_left == '0);
            if (last) parse_phase = AWAIT_OPCODE;
            expect_result(wsfd_pkg::KIND_DATA, b ^ key_byte, last);
         end
         default: begin
            // Halted: bytes are taken but nothing more comes out until reset.
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Sender side. The byte is offered after a random gap and held until the
   // transfer; valid stays high afterwards so that back-to-back bytes are
   // never interrupted by a lowered valid.
   // ------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.stream_byte <= b;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      bytes_accepted++;
      decode_stream_byte(b);
   endtask

   // First byte, second byte and any extended length bytes, big-endian.
   task automatic send_header(input logic [7:0] first_byte, input logic masked,
                              input logic [63:0] length, input length_form_type form);
      logic [6:0] len7;
      case (form)
         SHORT_LEN: len7 = length[6:0];
         EXT16_LEN: len7 = wsfd_pkg::LEN7_EXT16;
         default:   len7 = wsfd_pkg::LEN7_EXT64;
      endcase
      send_byte(first_byte);
      send_byte({masked, len7});
      if (form == EXT16_LEN) begin
         send_byte(length[15:8]);
         send_byte(length[7:0]);
      end else if (form == EXT64_LEN) begin
         for (int i = 7; i >= 0; i--) send_byte(length[8 * i +: 8]);
      end
   endtask

   task automatic send_frame(input logic [7:0] first_byte, input logic masked,
                             input logic [63:0] length, input length_form_type form);
      logic [31:0] key;
      key = $urandom;
      send_header(first_byte, masked, length, form);
      if (masked) begin
         for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
      end
      repeat (length) send_byte(8'($urandom));
   endtask

   // Lowers valid and waits until every predicted result has been taken,
   // then lets the pipeline settle, so that the block is known to be idle.
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The limit register is only ever written while the decoder is idle.
   task automatic write_limit(input logic [LW-1:0] value);
      wait_for_drain();
      csr_chan.valid           <= 1'b1;
      csr_chan.max_payload_len <= value;
      do @(posedge clock); while (!(csr_chan.valid && csr_chan.ready));
      csr_chan.valid <= 1'b0;
      length_limit = value;
   endtask

   // ------------------------------------------------------------------------
   // Receiver side. Ready is drawn at random each cycle, except while a long
   // hold-off is being served; the hold-off is counted here, in this process,
   // so the sender carries on offering bytes and the decoder has to stall.
   // ------------------------------------------------------------------------
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_requested != stall_served) begin
            stall_served = stall_requested;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_STALL_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Every result transfer is compared, field by field, with the oldest
   // prediction. A result with nothing waiting is a failure in itself.
   initial begin
      decoded_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (expected_results.size() == 0) begin
               $error("result transfer with no result expected: kind %0d opcode %0d",
                      rsp_chan.kind, rsp_chan.frame_opcode);
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_chan.kind !== want.kind) begin
                  $error("kind mismatch: expected %0d, actual %0d", want.kind, rsp_chan.kind);
                  failures++;
               end
               if (rsp_chan.frame_opcode !== want.opcode) begin
                  $error("frame_opcode mismatch: expected %0d, actual %0d",
                         want.opcode, rsp_chan.frame_opcode);
                  failures++;
               end
               if (rsp_chan.payload_byte !== want.data) begin
                  $error("payload_byte mismatch: expected %0d, actual %0d",
                         want.data, rsp_chan.payload_byte);
                  failures++;
               end
               if (rsp_chan.frame_end !== want.last) begin
                  $error("frame_end mismatch: expected %0d, actual %0d",
                         want.last, rsp_chan.frame_end);
                  failures++;
               end
               case (want.kind)
                  wsfd_pkg::KIND_DATA:  data_results++;
                  wsfd_pkg::KIND_EMPTY: empty_results++;
                  default:              error_results++;
               endcase
            end
         end
      end
   end

   // Watchdog: counts cycles without a transfer on any channel. It also
   // records how long the input was held off, as a sign of back-pressure.
   initial begin
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (!reset && req_chan.valid && !req_chan.ready) input_stall_cycles++;
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
             || (csr_chan.valid && csr_chan.ready) || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_results.size());
      $display("testbench NOT OK");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Short directed frames at the reset limit: an empty unmasked frame made
   // of all-zero bytes, an empty masked frame whose result falls on the last
   // key byte, a masked frame long enough for the key to wrap round, and an
   // unmasked frame with a 16-bit length carrying the byte extremes.
   task automatic test_directed_headers();
      send_frame(8'h00, 1'b0, 64'd0, SHORT_LEN);
      send_frame(8'hFF, 1'b1, 64'd0, SHORT_LEN);
      send_frame(8'h8A, 1'b1, 64'd5, SHORT_LEN);
      send_header(8'h81, 1'b0, 64'd2, EXT16_LEN);
      send_byte(8'h00);
      send_byte(8'hFF);
   endtask

   // With a zero limit only empty frames pass, here in all three encodings;
   // the 16 and 64-bit zero lengths are non-minimal but legal.
   task automatic test_zero_limit();
      write_limit('0);
      send_frame(8'($urandom), 1'($urandom), 64'd0, SHORT_LEN);
      send_frame(8'($urandom), 1'b1, 64'd0, EXT16_LEN);
      send_frame(8'($urandom), 1'($urandom), 64'd0, EXT64_LEN);
   endtask

   // A length equal to the limit is accepted, in every encoding. The second
   // limit has every one of its lower twenty bits set.
   task automatic test_limit_boundary();
      logic [LW-1:0] limit;
      limit = LW'($urandom_range(125, 1));
      write_limit(limit);
      send_frame(8'($urandom), 1'($urandom), 64'(limit), SHORT_LEN);
      send_frame(8'($urandom), 1'($urandom), 64'(limit), EXT16_LEN);
      send_frame(8'($urandom), 1'($urandom), 64'(limit), EXT64_LEN);
      send_frame(8'($urandom), 1'($urandom), 64'(limit) - 64'd1, SHORT_LEN);
      write_limit(wsfd_pkg::MAX_PAYLOAD_RESET - 1'b1);
      send_frame(8'($urandom), 1'b1, 64'd200, EXT64_LEN);
   endtask

   // Random frames until a byte count is reached. Most are short; a few run to
   // 1200 bytes, and lengths above the limit are cut down to it, so the
   // limit itself is hit often when it is small.
   task automatic run_random_traffic(input int unsigned byte_goal);
      int unsigned     start;
      int unsigned     pick;
      logic [63:0]     len;
      length_form_type form;
      start = bytes_accepted;
      while (bytes_accepted - start < byte_goal) begin
         pick = $urandom_range(99);
         if (pick < 10)      len = 64'd0;
         else if (pick < 70) len = 64'($urandom_range(16, 1));
         else if (pick < 92) len = 64'($urandom_range(125, 17));
         else if (pick < 99) len = 64'($urandom_range(300, 126));
         else                len = 64'($urandom_range(1200, 301));
         if (len > 64'(length_limit)) len = 64'(length_limit);
         pick = $urandom_range(9);
         if (len <= 64'd125 && pick < 6) form = SHORT_LEN;
         else if (pick[0])               form = EXT16_LEN;
         else                            form = EXT64_LEN;
         send_frame(8'($urandom), 1'($urandom), len, form);
      end
   endtask

   // Three idling profiles, each under its own limit.
   task automatic test_traffic_profiles();
      send_idle_pct = 34;
      recv_idle_pct = 83;
      write_limit(wsfd_pkg::MAX_PAYLOAD_RESET);
      run_random_traffic(TRAFFIC_BYTES);
      send_idle_pct = 83;
      recv_idle_pct = 34;
      write_limit(LW'($urandom_range(wsfd_pkg::MAX_PAYLOAD_RESET, 40)));
      run_random_traffic(TRAFFIC_BYTES);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_limit(LW'($urandom_range(1200, 126)));
      run_random_traffic(TRAFFIC_BYTES);
   endtask

   // The receiver holds off for a long stretch while bytes keep coming, so
   // the result register fills and the input must be stalled.
   task automatic test_back_pressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_limit(wsfd_pkg::MAX_PAYLOAD_RESET);
      stall_requested++;
      send_frame(8'($urandom), 1'($urandom), 64'd60, EXT16_LEN);
   endtask

   // An over-limit length gives one error result, and the halted parser then
   // takes further bytes without a word. This has to come last, since only a
   // reset would bring the parser back.
   task automatic test_oversize_halt();
      logic [LW-1:0]   limit;
      logic [63:0]     len;
      length_form_type form;
      case ($urandom_range(2))
         0: begin
            form  = SHORT_LEN;
            limit = LW'($urandom_range(124, 0));
            len   = 64'($urandom_range(125, int'(limit) + 1));
         end
         1: begin
            form  = EXT16_LEN;
            limit = LW'($urandom_range(65534, 0));
            len   = 64'($urandom_range(65535, int'(limit) + 1));
         end
         default: begin
            form  = EXT64_LEN;
            limit = LW'($urandom_range(wsfd_pkg::MAX_PAYLOAD_RESET, 0));
            // Either just over the limit or a wild length with high bits set.
            len   = $urandom_range(1) ? 64'(limit) + 64'd1 : {$urandom, $urandom};
            if (len <= 64'(limit)) len = 64'(limit) + 64'd1;
         end
      endcase
      write_limit(limit);
      send_header(8'($urandom), 1'($urandom), len, form);
      repeat (16) send_byte(8'($urandom));
   endtask

   // ------------------------------------------------------------------------
   // Main sequence. Reset is applied once, here, and never again.
   // ------------------------------------------------------------------------
   initial begin
      reset                    <= 1'b1;
      req_chan.valid           <= 1'b0;
      req_chan.stream_byte     <= '0;
      csr_chan.valid           <= 1'b0;
      csr_chan.max_payload_len <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 34;
      recv_idle_pct = 83;
      test_directed_headers();
      test_zero_limit();
      test_limit_boundary();
      test_traffic_profiles();
      test_back_pressure();
      test_oversize_halt();

      // The watchdog catches any prediction that never arrives here.
      wait_for_drain();

      $display("Covered %0d stream bytes in frames of all three length encodings,",
               bytes_accepted);
      $display("%0d payload, %0d empty-frame and %0d oversize results; input held %0d cycles.",
               data_results, empty_results, error_results, input_stall_cycles);
      if (failures == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/wsfd_pkg.sv
rtl/core/wsfd_channels.sv
rtl/core/wsfd_parser.sv
rtl/core/websocket_frame_decoder.sv
tb/sv/testbench.sv
